>>> rtl/mvrm_pkg.sv
// Shared types and constants for the multi-voice resampling mixer.
// No dependencies; imported by every mixer module.
`default_nettype none
package mvrm_pkg;

   localparam int SOURCES_DEF    = 32;
   localparam int RING_DEPTH_DEF = 8192;

   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 18;
   localparam int CH_W     = 4;
   localparam int QMS_W    = 10;
   localparam int CUR_W    = 30;
   localparam int STEP_W   = 19;
   localparam int TICK_W   = 32;
   localparam int CAP_W    = RATE_W + QMS_W;

   localparam logic [RATE_W-1:0] OUT_RATE   = RATE_W'(48000);
   localparam logic [TICK_W-1:0] IDLE_LIMIT = TICK_W'(400);
   localparam logic [CUR_W-1:0]  Q16_ONE    = CUR_W'(65536);
   localparam logic [STEP_W-1:0] STEP_UNITY = STEP_W'(65536);
   localparam int                MS_PER_S   = 1000;

   // step = floor(rate * 512 / 375), exact for 18-bit rates with this reciprocal
   localparam longint unsigned STEP_MUL = ((64'd1 << 36) + 64'd374) / 64'd375;
   localparam logic [13:0] STEP_MUL_LO = STEP_MUL[13:0];
   localparam logic [13:0] STEP_MUL_HI = STEP_MUL[27:14];
   localparam int          STEP_SHIFT  = 27;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = QMS_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_MS = 1'b1;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_MIX  = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   typedef struct packed {
      logic [1:0]                  mode;
      logic [4:0]                  slot;
      logic signed [SAMPLE_W-1:0]  sample_left;
      logic signed [SAMPLE_W-1:0]  sample_right;
      logic [RATE_W-1:0]           rate;
      logic [CH_W-1:0]             channels;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  mix_left;
      logic signed [SAMPLE_W-1:0]  mix_right;
      logic                        active;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic step_hi;
      logic write;
      logic drop;
      logic rd0;
      logic rd1;
      logic mul;
      logic acc;
      logic retire;
      logic next;
      logic tick_inc;
      logic tick_chk;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       enable;
      logic       push_ok;
      logic       interp_ok;
      logic       over_cap;
      logic       last_slot;
      logic       out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/mvrm_ctrl.sv
// Sequencer for the mixer: decodes each request and steps the datapath.
// Depends on mvrm_pkg (command and status structs, mode codes).
`default_nettype none
module mvrm_ctrl
   import mvrm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_DECODE = 14'b00000000000010,
      S_PREP   = 14'b00000000000100,
      S_STEP   = 14'b00000000001000,
      S_WRITE  = 14'b00000000010000,
      S_CAP    = 14'b00000000100000,
      S_MEVAL  = 14'b00000001000000,
      S_MRD1   = 14'b00000010000000,
      S_MMUL   = 14'b00000100000000,
      S_MACC   = 14'b00001000000000,
      S_MRET   = 14'b00010000000000,
      S_OUT    = 14'b00100000000000,
      S_TICK   = 14'b01000000000000,
      S_SPARE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.mode)
               MODE_PUSH: state_in = status.push_ok ? S_PREP : S_IDLE;
               MODE_MIX:  state_in = status.enable ? S_MEVAL : S_OUT;
               MODE_TICK: begin
                  if (status.enable) begin
                     cmd.tick_inc = 1'b1;
                     state_in     = S_TICK;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step_hi = 1'b1;
            state_in    = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_CAP;
         end
         S_CAP: begin
            if (status.over_cap) cmd.drop = 1'b1;
            else                 state_in = S_IDLE;
         end
         S_MEVAL: begin
            if (status.interp_ok) begin
               cmd.rd0  = 1'b1;
               state_in = S_MRD1;
            end else begin
               state_in = S_MRET;
            end
         end
         S_MRD1: begin
            cmd.rd1  = 1'b1;
            state_in = S_MMUL;
         end
         S_MMUL: begin
            cmd.mul  = 1'b1;
            state_in = S_MACC;
         end
         S_MACC: begin
            cmd.acc  = 1'b1;
            state_in = S_MRET;
         end
         S_MRET: begin
            cmd.retire = 1'b1;
            if (status.last_slot) begin
               state_in = S_OUT;
            end else begin
               cmd.next = 1'b1;
               state_in = S_MEVAL;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TICK: begin
            cmd.tick_chk = 1'b1;
            if (status.last_slot) state_in = S_IDLE;
            else                  cmd.next = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/mvrm_dp.sv
// Mixer datapath: per-slot state, sample ring memory, interpolation and sum.
// Depends on mvrm_pkg; driven by mvrm_ctrl commands.
`default_nettype none
module mvrm_dp
   import mvrm_pkg::*;
#(
   parameter int SOURCES    = SOURCES_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_payload_type       req_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data
);

   localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int HW    = $clog2(RING_DEPTH);
   localparam int CW    = $clog2(RING_DEPTH + 1);
   localparam int AW    = $clog2(SOURCES * RING_DEPTH);
   localparam int ACC_W = SAMPLE_W + SW + 2;
   localparam int MEM_N = SOURCES * RING_DEPTH;

   // configuration
   logic                enable_ff;
   logic [QMS_W-1:0]    queue_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         queue_ms_ff <= QMS_W'(120);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            CSR_QUEUE_MS: queue_ms_ff <= csr_wdata[QMS_W-1:0];
            default: ;
         endcase
      end
   end

   // latched request
   logic [1:0]                 mode_ff;
   logic                       push_ok_ff;
   logic [RATE_W-1:0]          rate_ff;
   logic [CH_W-1:0]            ch_ff;
   logic [2*SAMPLE_W-1:0]      frame_ff;
   logic [SW-1:0]              sidx_ff;

   // per-slot state
   logic                slot_live_ff   [SOURCES];
   logic [RATE_W-1:0]   slot_rate_ff   [SOURCES];
   logic [CH_W-1:0]     slot_ch_ff     [SOURCES];
   logic [HW-1:0]       slot_head_ff   [SOURCES];
   logic [CW-1:0]       slot_count_ff  [SOURCES];
   logic [CUR_W-1:0]    slot_cursor_ff [SOURCES];
   logic [TICK_W-1:0]   slot_last_ff   [SOURCES];
   logic [STEP_W-1:0]   slot_step_ff   [SOURCES];
   logic [TICK_W-1:0]   tick_ff;

   logic [CAP_W-1:0]    cap_ff;
   logic [31:0]         plo_ff, phi_ff;
   logic [SAMPLE_W-1:0] a0l_ff, a0r_ff;
   logic signed [33:0]  prodl_ff, prodr_ff;
   logic [2*SAMPLE_W-1:0] rdata_ff;
   logic signed [ACC_W-1:0] suml_ff, sumr_ff;
   logic                any_ff;

   // current slot view
   logic                cur_live;
   logic [RATE_W-1:0]   cur_rate;
   logic [CH_W-1:0]     cur_ch;
   logic [HW-1:0]       cur_head;
   logic [CW-1:0]       cur_count;
   logic [CUR_W-1:0]    cur_cursor;
   logic [13:0]         cur_idx;

   assign cur_live   = slot_live_ff[sidx_ff];
   assign cur_rate   = slot_rate_ff[sidx_ff];
   assign cur_ch     = slot_ch_ff[sidx_ff];
   assign cur_head   = slot_head_ff[sidx_ff];
   assign cur_count  = slot_count_ff[sidx_ff];
   assign cur_cursor = slot_cursor_ff[sidx_ff];
   assign cur_idx    = cur_cursor[CUR_W-1:16];

   function automatic logic [HW-1:0] wrap_pos(input logic [31:0] p);
      logic [31:0] q;
      q = (p >= 32'(RING_DEPTH)) ? p - 32'(RING_DEPTH) : p;
      return q[HW-1:0];
   endfunction

   // ring positions
   logic          full;
   logic [HW-1:0] wpos, rpos, drop_head;
   logic [AW-1:0] waddr, raddr;
   logic [CUR_W-1:0] drop_cursor;

   assign full      = (32'(cur_count) == 32'(RING_DEPTH));
   assign wpos      = full ? cur_head : wrap_pos(32'(cur_head) + 32'(cur_count));
   assign rpos      = wrap_pos(32'(cur_head) + 32'(cur_idx) + 32'(cmd.rd1));
   assign waddr     = AW'(sidx_ff) * AW'(RING_DEPTH) + AW'(wpos);
   assign raddr     = AW'(sidx_ff) * AW'(RING_DEPTH) + AW'(rpos);
   assign drop_head = wrap_pos(32'(cur_head) + 32'd1);
   assign drop_cursor = (cur_cursor > Q16_ONE) ? cur_cursor - Q16_ONE : '0;

   logic [2*SAMPLE_W-1:0] ring_ff [MEM_N];

   always_ff @(posedge clock) begin
      if (cmd.write) ring_ff[waddr] <= frame_ff;
      if (cmd.rd0 || cmd.rd1) rdata_ff <= ring_ff[raddr];
   end

   // step and cap arithmetic
   logic [45:0]         step_full;
   logic [STEP_W-1:0]   step_new;
   assign step_full = {phi_ff, 14'd0} + 46'(plo_ff);
   assign step_new  = STEP_W'(step_full >> STEP_SHIFT);

   logic over_cap;
   assign over_cap = (32'(cur_count) * 32'(MS_PER_S)) > 32'(cap_ff);

   // interpolation
   logic signed [16:0] dl, dr, f17;
   assign dl  = $signed({rdata_ff[31], rdata_ff[31:16]}) - $signed({a0l_ff[15], a0l_ff});
   assign dr  = $signed({rdata_ff[15], rdata_ff[15:0]}) - $signed({a0r_ff[15], a0r_ff});
   assign f17 = $signed({1'b0, cur_cursor[15:0]});

   logic signed [33:0] rndl, rndr;
   logic signed [17:0] ipl, ipr;
   assign rndl = (prodl_ff + 34'sd32768) >>> 16;
   assign rndr = (prodr_ff + 34'sd32768) >>> 16;
   assign ipl  = $signed({{2{a0l_ff[15]}}, a0l_ff}) + rndl[17:0];
   assign ipr  = $signed({{2{a0r_ff[15]}}, a0r_ff}) + rndr[17:0];

   // retire
   logic [13:0] consumed;
   logic [31:0] nret;
   assign consumed = (cur_cursor > Q16_ONE) ? cur_idx - 14'd1 : 14'd0;
   assign nret     = (32'(consumed) < 32'(cur_count)) ? 32'(consumed) : 32'(cur_count);

   logic idle_expired;
   assign idle_expired = cur_live && ((tick_ff - slot_last_ff[sidx_ff]) > IDLE_LIMIT);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         cap_ff <= CAP_W'(rate_ff) * CAP_W'(queue_ms_ff);
         plo_ff <= 32'(rate_ff) * 32'(STEP_MUL_LO);
      end
      if (cmd.step_hi) phi_ff <= 32'(rate_ff) * 32'(STEP_MUL_HI);
      if (cmd.rd1) begin
         a0l_ff <= rdata_ff[31:16];
         a0r_ff <= rdata_ff[15:0];
      end
      if (cmd.mul) begin
         prodl_ff <= dl * f17;
         prodr_ff <= dr * f17;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) begin
            slot_live_ff[i]   <= 1'b0;
            slot_rate_ff[i]   <= OUT_RATE;
            slot_ch_ff[i]     <= CH_W'(2);
            slot_head_ff[i]   <= '0;
            slot_count_ff[i]  <= '0;
            slot_cursor_ff[i] <= '0;
            slot_last_ff[i]   <= '0;
            slot_step_ff[i]   <= STEP_UNITY;
         end
         tick_ff    <= '0;
         sidx_ff    <= '0;
         mode_ff    <= '0;
         push_ok_ff <= 1'b0;
         suml_ff    <= '0;
         sumr_ff    <= '0;
         any_ff     <= 1'b0;
      end else begin
         if (cmd.load) begin
            mode_ff    <= req_data.mode;
            push_ok_ff <= (req_data.channels != '0) && (32'(req_data.slot) < 32'(SOURCES));
            rate_ff    <= (req_data.rate == '0) ? OUT_RATE : req_data.rate;
            ch_ff      <= req_data.channels;
            frame_ff   <= {req_data.sample_left,
                           (req_data.channels > CH_W'(1)) ? req_data.sample_right
                                                          : req_data.sample_left};
            sidx_ff    <= (req_data.mode == MODE_PUSH) ? req_data.slot[SW-1:0] : '0;
            suml_ff    <= '0;
            sumr_ff    <= '0;
            any_ff     <= 1'b0;
         end
         if (cmd.next) sidx_ff <= sidx_ff + SW'(1);
         if (cmd.tick_inc) tick_ff <= tick_ff + TICK_W'(1);
         // a new stream or a format change starts the slot empty
         if (cmd.prep && (!cur_live || cur_rate != rate_ff || cur_ch != ch_ff)) begin
            slot_live_ff[sidx_ff]   <= 1'b1;
            slot_rate_ff[sidx_ff]   <= rate_ff;
            slot_ch_ff[sidx_ff]     <= ch_ff;
            slot_head_ff[sidx_ff]   <= '0;
            slot_count_ff[sidx_ff]  <= '0;
            slot_cursor_ff[sidx_ff] <= '0;
         end
         if (cmd.write) begin
            slot_step_ff[sidx_ff] <= step_new;
            slot_last_ff[sidx_ff] <= tick_ff;
            if (full) begin
               // overwrite the oldest entry in place
               slot_head_ff[sidx_ff]   <= drop_head;
               slot_cursor_ff[sidx_ff] <= drop_cursor;
            end else begin
               slot_count_ff[sidx_ff] <= cur_count + CW'(1);
            end
         end
         if (cmd.drop) begin
            slot_head_ff[sidx_ff]   <= drop_head;
            slot_count_ff[sidx_ff]  <= cur_count - CW'(1);
            slot_cursor_ff[sidx_ff] <= drop_cursor;
         end
         if (cmd.acc) begin
            suml_ff <= suml_ff + ACC_W'(ipl);
            sumr_ff <= sumr_ff + ACC_W'(ipr);
            any_ff  <= 1'b1;
            slot_cursor_ff[sidx_ff] <= cur_cursor + CUR_W'(slot_step_ff[sidx_ff]);
         end
         if (cmd.retire && consumed != '0) begin
            slot_head_ff[sidx_ff]   <= wrap_pos(32'(cur_head) + nret);
            slot_count_ff[sidx_ff]  <= cur_count - CW'(nret);
            slot_cursor_ff[sidx_ff] <= cur_cursor - {consumed, 16'd0};
         end
         if (cmd.tick_chk && idle_expired) begin
            slot_live_ff[sidx_ff]   <= 1'b0;
            slot_rate_ff[sidx_ff]   <= OUT_RATE;
            slot_ch_ff[sidx_ff]     <= CH_W'(2);
            slot_head_ff[sidx_ff]   <= '0;
            slot_count_ff[sidx_ff]  <= '0;
            slot_cursor_ff[sidx_ff] <= '0;
            slot_last_ff[sidx_ff]   <= '0;
            slot_step_ff[sidx_ff]   <= STEP_UNITY;
         end
      end
   end

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic            out_free;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(32767))       return 16'sh7FFF;
      else if (v < -ACC_W'(32768)) return 16'sh8000;
      else                         return v[SAMPLE_W-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.mix_left  <= sat16(suml_ff);
         rsp_data_ff.mix_right <= sat16(sumr_ff);
         rsp_data_ff.active    <= any_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status           = '0;
      status.mode      = mode_ff;
      status.enable    = enable_ff;
      status.push_ok   = push_ok_ff && enable_ff;
      status.interp_ok = cur_live && ((32'(cur_idx) + 32'd1) < 32'(cur_count));
      status.over_cap  = over_cap;
      status.last_slot = (32'(sidx_ff) == 32'(SOURCES - 1));
      status.out_free  = out_free;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cur_count) <= 32'(RING_DEPTH))
      else $error("slot count above ring depth");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rd0 |-> status.interp_ok)
      else $error("ring read for a slot without two banked samples");

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result loaded over an unaccepted result");

   a_any_sum: assert property (@(posedge clock) disable iff (reset)
      !any_ff |-> (suml_ff == '0 && sumr_ff == '0))
      else $error("sum nonzero with no contributing slot");

endmodule
`default_nettype wire

>>> rtl/multi_voice_resampling_mixer.sv
// Multi-voice resampling mixer: interpolating mixer over per-slot sample rings.
// Top level; instantiates mvrm_ctrl and mvrm_dp, uses mvrm_pkg.
`default_nettype none
// One request at a time. A push computes the step and queue limit, writes the
// sample and drops the oldest samples while the slot is over its queue limit
// (can be many after queue_ms is lowered). With the mixer on, a mix reads,
// interpolates, accumulates and retires each contributing slot and only retires
// an idle or underrun slot, a sequence set by the single read port of the ring
// memory. A tick checks one slot per cycle. An ignored push, a tick with the
// mixer off and an unused mode end after decode. A finished mix sits in an output
// register, so a new request is taken while it waits.
module multi_voice_resampling_mixer
   import mvrm_pkg::*;
#(
   parameter int SOURCES    = SOURCES_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mvrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mvrm_dp #(
      .SOURCES    (SOURCES),
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> dv/tb_multi_voice_resampling_mixer.sv
// Testbench for multi_voice_resampling_mixer: random and directed push/mix/tick
// beats, checked against an in-bench model of the slot rings. Uses mvrm_pkg.
`default_nettype none
module tb_multi_voice_resampling_mixer;
   import mvrm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 32;
   localparam int DEPTH = 8192;
   localparam logic [1:0] MODE_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   multi_voice_resampling_mixer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mixer model state
   shortint ring_l [NSLOT][DEPTH];
   shortint ring_r [NSLOT][DEPTH];
   bit          live [NSLOT];
   int unsigned srate [NSLOT], schan [NSLOT], head [NSLOT], cnt [NSLOT];
   int unsigned cursor [NSLOT], last_tick [NSLOT];
   int unsigned tick_count;
   bit          mix_on;
   int unsigned qms;

   req_payload_type pend_q [$];
   rsp_payload_type mix_q [$];
   int errors = 0;
   bit req_fire = 1'b0;
   int unsigned rate_tab [NSLOT];
   int unsigned ch_tab [NSLOT];

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void empty_slot(int s);
      head[s] = 0;
      cnt[s] = 0;
      cursor[s] = 0;
   endfunction

   function automatic void free_slot(int s);
      empty_slot(s);
      live[s] = 0;
      srate[s] = 48000;
      schan[s] = 2;
      last_tick[s] = 0;
   endfunction

   function automatic void drop_oldest(int s);
      if (cnt[s] == 0) return;
      head[s] = (head[s] + 1) % DEPTH;
      cnt[s]--;
      cursor[s] = (cursor[s] > 65536) ? cursor[s] - 65536 : 0;
   endfunction

   function automatic int lerp(int a, int b, int unsigned f);
      longint unsigned v;
      v = longint'(a + 32768) * (65536 - f) + longint'(b + 32768) * f;
      return int'((v + 32768) >> 16) - 32768;
   endfunction

   function automatic int sat16(int v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic void push_frame(req_payload_type it);
      int s;
      int unsigned rt, ch, a, cap;
      shortint l, r;
      s = it.slot;
      rt = it.rate;
      ch = it.channels;
      l = it.sample_left;
      r = (ch > 1) ? it.sample_right : it.sample_left;
      if (!mix_on || ch == 0) return;
      if (rt == 0) rt = 48000;
      if (!live[s]) begin
         free_slot(s);
         live[s] = 1;
      end
      if (srate[s] != rt || schan[s] != ch) begin
         empty_slot(s);
         srate[s] = rt;
         schan[s] = ch;
      end
      if (cnt[s] >= DEPTH) drop_oldest(s);
      a = (head[s] + cnt[s]) % DEPTH;
      ring_l[s][a] = l;
      ring_r[s][a] = r;
      cnt[s]++;
      last_tick[s] = tick_count;
      cap = int'((longint'(srate[s]) * qms) / 1000);
      if (cap > DEPTH) cap = DEPTH;
      while (cnt[s] > cap) drop_oldest(s);
   endfunction

   function automatic rsp_payload_type mix_sample();
      rsp_payload_type o;
      int sl, sr;
      bit any;
      int unsigned idx, f, a0, a1, stp, used, n;
      sl = 0;
      sr = 0;
      any = 0;
      if (mix_on) begin
         for (int s = 0; s < NSLOT; s++) begin
            if (!live[s]) continue;
            idx = cursor[s] >> 16;
            if (idx + 1 < cnt[s]) begin
               f = cursor[s] & 32'hFFFF;
               a0 = (head[s] + idx) % DEPTH;
               a1 = (head[s] + idx + 1) % DEPTH;
               sl += lerp(ring_l[s][a0], ring_l[s][a1], f);
               sr += lerp(ring_r[s][a0], ring_r[s][a1], f);
               stp = int'((longint'(srate[s]) << 16) / 48000);
               cursor[s] = (cursor[s] + stp) & 32'h3FFF_FFFF;
               any = 1;
            end
            used = (cursor[s] > 65536) ? (cursor[s] >> 16) - 1 : 0;
            if (used != 0) begin
               n = (used < cnt[s]) ? used : cnt[s];
               head[s] = (head[s] + n) % DEPTH;
               cnt[s] -= n;
               cursor[s] -= used << 16;
            end
         end
      end
      if (!any) begin
         sl = 0;
         sr = 0;
      end
      o.mix_left = 16'(sat16(sl));
      o.mix_right = 16'(sat16(sr));
      o.active = any;
      return o;
   endfunction

   function automatic void end_frame();
      if (!mix_on) return;
      tick_count++;
      for (int s = 0; s < NSLOT; s++)
         if (live[s] && (tick_count - last_tick[s]) > 400) free_slot(s);
   endfunction

   // accept side: model update and result check
   always @(posedge clock) begin
      req_fire = req_valid && req_ready && !reset;
      if (req_fire) begin
         case (req_data.mode)
            MODE_PUSH: push_frame(req_data);
            MODE_MIX:  mix_q = {mix_q, mix_sample()};
            MODE_TICK: end_frame();
            default: ;
         endcase
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (mix_q.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            errors++;
         end else begin
            rsp_payload_type e;
            e = mix_q[0];
            mix_q.delete(0);
            if (e.mix_left !== rsp_data.mix_left) begin
               $error("mix_left exp %0d got %0d", e.mix_left, rsp_data.mix_left);
               errors++;
            end
            if (e.mix_right !== rsp_data.mix_right) begin
               $error("mix_right exp %0d got %0d", e.mix_right, rsp_data.mix_right);
               errors++;
            end
            if (e.active !== rsp_data.active) begin
               $error("active exp %0d got %0d", e.active, rsp_data.active);
               errors++;
            end
         end
      end
   end

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pend_q.size() > 0) begin
            req_data <= pend_q[0];
            pend_q.delete(0);
            req_valid <= 1'b1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 12);
            end
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: shifting stall pattern plus one long hold-off
   int rx_beats = 0;
   int hold_left = 0;
   bit held = 0;
   int rx_cyc = 0;
   int rx_style = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) rx_beats++;
         rx_cyc++;
         if (rx_cyc % 64 == 0) rx_style = $urandom_range(2);
         if (!held && rx_beats == 150) begin
            held = 1;
            hold_left = 2500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(1);
               default: rsp_ready <= ($urandom_range(4) == 0);
            endcase
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ENABLE) mix_on = val[0];
      else qms = val & 32'h3FF;
   endtask

   task automatic drain_all();
      wait (pend_q.size() == 0 && !req_valid);
      wait (mix_q.size() == 0);
      // a push may still be dropping samples
      repeat (9000) @(posedge clock);
   endtask

   function automatic void queue_item(req_payload_type it);
      pend_q = {pend_q, it};
   endfunction

   function automatic req_payload_type beat(logic [1:0] m, int s, int l, int r,
                                            int unsigned rt, int unsigned ch);
      req_payload_type it;
      it.mode = m;
      it.slot = 5'(s);
      it.sample_left = 16'(l);
      it.sample_right = 16'(r);
      it.rate = 18'(rt);
      it.channels = 4'(ch);
      return it;
   endfunction

   function automatic req_payload_type rand_beat();
      int unsigned p, s;
      logic [63:0] rbits;
      req_payload_type it;
      rbits = {$urandom, $urandom};
      it = rbits[$bits(req_payload_type)-1:0];
      p = $urandom_range(99);
      if (p < 50) begin
         s = ($urandom_range(4) != 0) ? $urandom_range(3) : $urandom_range(31);
         it.mode = MODE_PUSH;
         it.slot = 5'(s);
         if ($urandom_range(19) != 0) it.rate = 18'(rate_tab[s]);
         if ($urandom_range(9) != 0) it.channels = 4'(ch_tab[s]);
      end else if (p < 90) begin
         it.mode = MODE_MIX;
      end else if (p < 97) begin
         it.mode = MODE_TICK;
      end else begin
         it.mode = MODE_NONE;
      end
      return it;
   endfunction

   initial begin
      int unsigned rates [9] = '{8000, 11025, 22050, 44100, 48000, 0, 96000, 262143, 1};
      int unsigned ph_en [6] = '{1, 1, 1, 1, 0, 1};
      int unsigned ph_q  [6] = '{120, 1, 0, 1000, 1000, 7};
      for (int s = 0; s < NSLOT; s++) begin
         free_slot(s);
         rate_tab[s] = rates[$urandom_range(8)];
         ch_tab[s] = $urandom_range(1, 2);
      end
      rate_tab[0] = 48000;
      tick_count = 0;
      mix_on = 0;
      qms = 120;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening
      csr_write(CSR_ENABLE, 1);
      csr_write(CSR_QUEUE_MS, 120);
      queue_item(beat(MODE_MIX, 0, 0, 0, 0, 2));
      queue_item(beat(MODE_PUSH, 0, 32767, -32768, 48000, 2));
      queue_item(beat(MODE_PUSH, 0, -32768, 32767, 48000, 2));
      queue_item(beat(MODE_PUSH, 0, 100, -100, 48000, 2));
      queue_item(beat(MODE_PUSH, 1, -5, 999, 0, 1));
      queue_item(beat(MODE_PUSH, 1, 7, 999, 0, 1));
      queue_item(beat(MODE_PUSH, 1, 7, 999, 0, 0));
      for (int s = 2; s < 5; s++) begin
         queue_item(beat(MODE_PUSH, s, 32767, -32768, 24000, 2));
         queue_item(beat(MODE_PUSH, s, 32767, -32768, 24000, 2));
         queue_item(beat(MODE_PUSH, s, 32767, -32768, 24000, 2));
      end
      queue_item(beat(MODE_MIX, 31, 0, 0, 0, 2));
      queue_item(beat(MODE_MIX, 0, 0, 0, 0, 2));
      queue_item(beat(MODE_NONE, 0, 1, 1, 1, 1));
      queue_item(beat(MODE_TICK, 0, 0, 0, 0, 2));
      queue_item(beat(MODE_PUSH, 0, 1, 2, 44100, 8));
      queue_item(beat(MODE_PUSH, 31, -1, 1, 262143, 15));
      queue_item(beat(MODE_MIX, 0, 0, 0, 0, 2));
      drain_all();

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_ENABLE, ph_en[ph]);
         csr_write(CSR_QUEUE_MS, ph_q[ph]);
         for (int i = 0; i < 110; i++) queue_item(rand_beat());
         drain_all();
         if (ph == 0) begin
            // idle release: slot 5 goes stale, slot 6 stays fresh
            for (int i = 0; i < 3; i++)
               queue_item(beat(MODE_PUSH, 5, $urandom, $urandom, 48000, 2));
            for (int i = 0; i < 200; i++) queue_item(beat(MODE_TICK, 0, 0, 0, 0, 2));
            for (int i = 0; i < 3; i++)
               queue_item(beat(MODE_PUSH, 6, $urandom, $urandom, 48000, 2));
            for (int i = 0; i < 202; i++) queue_item(beat(MODE_TICK, 0, 0, 0, 0, 2));
            for (int i = 0; i < 5; i++) queue_item(beat(MODE_MIX, 0, 0, 0, 0, 2));
            drain_all();
         end
      end
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #15ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/mvrm_pkg.sv
rtl/mvrm_ctrl.sv
rtl/mvrm_dp.sv
rtl/multi_voice_resampling_mixer.sv
dv/tb_multi_voice_resampling_mixer.sv
